FILE: design/wsdf_pkg.sv
// Shared constants for the WebSocket frame deframer.
package wsdf_pkg;

    localparam int PHASE_W = 3;

    // Parser phases; unused codes behave as PH_HDR0
    localparam logic [PHASE_W-1:0] PH_HDR0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_EMPTY = 1'b1;

endpackage

FILE: design/websocket_frame_deframer_top.sv
// WebSocket frame deframer: byte stream in, unmasked payload words out.
//
// Input channel: one received byte per word on i_in_byte, qualified by
// i_valid; the block holds it off with o_stall. Output channel: one result
// word per payload byte (o_kind = 0) or one word per zero-length frame
// (o_kind = 1), qualified by o_valid and held while i_stall is high.
// Header, extended-length and masking-key bytes produce no output word.
// Each output word carries the frame's opcode, FIN, decoded length and a
// last marker on the final word of the frame.
//
// A result word shows on o_valid in the cycle after its byte is accepted.
// The block takes one byte per cycle while o_stall is low: the parser state
// updates in the accept cycle and the result lands in a single output register,
// which is refilled in the same cycle it is taken. o_stall rises only while
// that register is full and the receiver stalls, so a stalled result costs no more than one held byte.
//
// Synchronous reset returns the parser to the first header byte and
// empties the output register.
module websocket_frame_deframer_top
    import wsdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_data,
    output logic [3:0]  o_opcode,
    output logic        o_fin,
    output logic [63:0] o_payload_length,
    output logic        o_last
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_fin, n_fin;
    logic [3:0]         r_opcode, n_opcode;
    logic               r_mask, n_mask;
    logic [2:0]         r_cnt, n_cnt;
    logic [63:0]        r_len, n_len;
    logic [31:0]        r_key, n_key;
    logic [63:0]        r_idx, n_idx;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [7:0]         r_out_data;
    logic [3:0]         r_out_opcode;
    logic               r_out_fin;
    logic [63:0]        r_out_len;
    logic               r_out_last;

    logic               accept;
    logic               emit;
    logic               res_kind;
    logic [7:0]         res_data;
    logic               res_last;
    logic [6:0]         len_code;
    logic [7:0]         key_byte;
    logic               is_last;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign len_code = i_in_byte[6:0];

    // key byte 0 sits in the top byte of r_key
    always_comb begin
        unique case (r_idx[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign is_last = (r_idx == (r_len - 64'd1));

    always_comb begin
        n_phase  = r_phase;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_key    = r_key;
        n_idx    = r_idx;
        emit     = 1'b0;
        res_kind = KIND_DATA;
        res_data = 8'd0;
        res_last = 1'b0;

        unique case (r_phase)
            PH_HDR1: begin
                n_mask = i_in_byte[7];
                if (len_code == LEN_CODE_EXT16 || len_code == LEN_CODE_EXT64) begin
                    n_len   = 64'd0;
                    n_cnt   = (len_code == LEN_CODE_EXT16) ? EXT16_BYTES_M1
                                                           : EXT64_BYTES_M1;
                    n_phase = PH_EXT;
                end else begin
                    n_len = {57'd0, len_code};
                    if (i_in_byte[7]) begin
                        n_key   = 32'd0;
                        n_cnt   = KEY_BYTES_M1;
                        n_phase = PH_KEY;
                    end else begin
                        n_idx = 64'd0;
                        if (len_code == 7'd0) begin
                            emit     = 1'b1;
                            res_kind = KIND_EMPTY;
                            res_last = 1'b1;
                            n_phase  = PH_HDR0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_EXT: begin
                n_len = {r_len[55:0], i_in_byte};
                if (r_cnt == 3'd0) begin
                    if (r_mask) begin
                        n_key   = 32'd0;
                        n_cnt   = KEY_BYTES_M1;
                        n_phase = PH_KEY;
                    end else begin
                        n_idx = 64'd0;
                        if (n_len == 64'd0) begin
                            emit     = 1'b1;
                            res_kind = KIND_EMPTY;
                            res_last = 1'b1;
                            n_phase  = PH_HDR0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_in_byte};
                if (r_cnt == 3'd0) begin
                    n_idx = 64'd0;
                    if (r_len == 64'd0) begin
                        emit     = 1'b1;
                        res_kind = KIND_EMPTY;
                        res_last = 1'b1;
                        n_phase  = PH_HDR0;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_DATA: begin
                emit     = 1'b1;
                res_kind = KIND_DATA;
                res_data = r_mask ? (i_in_byte ^ key_byte) : i_in_byte;
                res_last = is_last;
                n_idx    = r_idx + 64'd1;
                if (is_last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin    = i_in_byte[7];
                n_opcode = i_in_byte[3:0];
                n_phase  = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fin    <= 1'b0;
            r_opcode <= 4'd0;
            r_mask   <= 1'b0;
            r_cnt    <= 3'd0;
            r_len    <= 64'd0;
            r_key    <= 32'd0;
            r_idx    <= 64'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_kind   <= res_kind;
            r_out_data   <= res_data;
            r_out_opcode <= r_opcode;
            r_out_fin    <= r_fin;
            r_out_len    <= n_len;
            r_out_last   <= res_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_data           = r_out_data;
    assign o_opcode         = r_out_opcode;
    assign o_fin            = r_out_fin;
    assign o_payload_length = r_out_len;
    assign o_last           = r_out_last;

`ifndef SYNTH
    a_empty_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_EMPTY) |->
            (o_last && o_data == 8'd0 && o_payload_length == 64'd0))
        else $error("empty-frame word malformed");

    a_data_phase_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != 64'd0))
        else $error("payload phase with zero length");

    a_key_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY) |-> r_mask)
        else $error("key phase without mask flag");

    a_data_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_DATA) |=> o_valid)
        else $error("payload byte produced no output word");
`endif

endmodule

FILE: tb/tb_websocket_frame_deframer_top.sv
// Self-checking testbench for the WebSocket frame deframer top level.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;
    import wsdf_pkg::*;

    localparam int RANDOM_BYTES = 1400;
    localparam int LONG_HOLD    = 60;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        fin;
        logic [63:0] payload_length;
        logic        last;
    } t_deframe_word;

    // Parses the byte stream alongside the block and keeps the words it should emit.
    class frame_unmasker;
        t_deframe_word due_words[$];
        int            fails;
        logic [2:0]    phase;
        logic          fin_flag;
        logic [3:0]    opcode;
        logic          masked;
        logic [2:0]    hdr_left;
        logic [63:0]   length;
        logic [31:0]   key;
        logic [63:0]   index;

        function new();
            fails    = 0;
            phase    = PH_HDR0;
            fin_flag = 1'b0;
            opcode   = '0;
            masked   = 1'b0;
            hdr_left = '0;
            length   = '0;
            key      = '0;
            index    = '0;
        endfunction

        function void queue_word(logic kind, logic [7:0] data, logic last);
            t_deframe_word w;
            w.kind           = kind;
            w.data           = data;
            w.opcode         = opcode;
            w.fin            = fin_flag;
            w.payload_length = length;
            w.last           = last;
            due_words.insert(due_words.size(), w);
        endfunction

        function void start_payload();
            index = '0;
            if (length == 64'd0) begin
                queue_word(KIND_EMPTY, 8'h00, 1'b1);
                phase = PH_HDR0;
            end else begin
                phase = PH_DATA;
            end
        endfunction

        function void length_known();
            if (masked) begin
                key      = '0;
                hdr_left = KEY_BYTES_M1;
                phase    = PH_KEY;
            end else begin
                start_payload();
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] key_byte;
            logic       is_last;
            case (phase)
                PH_HDR1: begin
                    masked = b[7];
                    if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
                        length   = '0;
                        hdr_left = (b[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES_M1 : EXT64_BYTES_M1;
                        phase    = PH_EXT;
                    end else begin
                        length = 64'(b[6:0]);
                        length_known();
                    end
                end
                PH_EXT: begin
                    length = {length[55:0], b};
                    if (hdr_left == 3'd0) length_known();
                    else hdr_left = hdr_left - 3'd1;
                end
                PH_KEY: begin
                    key = {key[23:0], b};
                    if (hdr_left == 3'd0) start_payload();
                    else hdr_left = hdr_left - 3'd1;
                end
                PH_DATA: begin
                    // key bytes rotate from the top byte down
                    key_byte = masked ? key[8*(3 - int'(index[1:0])) +: 8] : 8'h00;
                    is_last  = (index == length - 64'd1);
                    queue_word(KIND_DATA, b ^ key_byte, is_last);
                    index = index + 64'd1;
                    if (is_last) phase = PH_HDR0;
                end
                default: begin
                    fin_flag = b[7];
                    opcode   = b[3:0];
                    phase    = PH_HDR1;
                end
            endcase
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_word(t_deframe_word got);
            t_deframe_word want;
            if (due_words.size() == 0) begin
                $error("word with nothing due: kind %0h data %0h", got.kind, got.data);
                fails++;
            end else begin
                want = due_words.pop_front();
                cmp("kind", 64'(want.kind), 64'(got.kind));
                cmp("data", 64'(want.data), 64'(got.data));
                cmp("opcode", 64'(want.opcode), 64'(got.opcode));
                cmp("fin", 64'(want.fin), 64'(got.fin));
                cmp("payload_length", want.payload_length, got.payload_length);
                cmp("last", 64'(want.last), 64'(got.last));
            end
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [7:0]  o_data;
    logic [3:0]  o_opcode;
    logic        o_fin;
    logic [63:0] o_payload_length;
    logic        o_last;

    frame_unmasker tracker;
    bit            steady        = 1'b0;
    bit            hold_long_req = 1'b0;
    int            bytes_sent    = 0;

    websocket_frame_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_data           (o_data),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // form: 0 = 7-bit length, 1 = 16-bit extended, else 64-bit extended
    task automatic send_frame(input logic [3:0] opc, input logic fin_b, input logic masked,
                              input int form, input logic [63:0] len, input int body_n,
                              input logic [31:0] key);
        push_byte({fin_b, 3'($urandom_range(0, 7)), opc});
        case (form)
            0: push_byte({masked, len[6:0]});
            1: begin
                push_byte({masked, LEN_CODE_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
        end
        repeat (body_n) push_byte(8'($urandom()));
    endtask

    function automatic int sink_wait();
        if (hold_long_req) begin
            hold_long_req = 1'b0;
            return LONG_HOLD;
        end
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    initial begin : sink
        int            hold;
        t_deframe_word got;
        @(posedge i_rst_n);
        hold = sink_wait();
        forever begin
            @(negedge i_clk);
            i_stall <= (hold > 0);
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (o_valid) begin
                got = '{o_kind, o_data, o_opcode, o_fin, o_payload_length, o_last};
                tracker.check_word(got);
                hold = sink_wait();
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("** websocket_frame_deframer_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int          r;
        int          form;
        logic [63:0] len;
        bit          pressed;
        bit          drained;
        tracker = new();
        pressed = 1'b0;
        drained = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unmasked empty, masked with key wrap, non-minimal 64/16-bit lengths
        send_frame(4'h0, 1'b0, 1'b0, 0, 64'd0, 0, 32'h0);
        send_frame(4'hF, 1'b1, 1'b1, 0, 64'd5, 5, 32'hFF00_A55A);
        send_frame(4'h9, 1'b1, 1'b0, 2, 64'd1, 1, 32'h0);
        send_frame(4'h2, 1'b0, 1'b0, 1, 64'd2, 2, 32'h0);

        while (bytes_sent < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                form = 0;
                if ($urandom_range(0, 9) == 0) len = 64'd0;
                else if ($urandom_range(0, 19) == 0) len = 64'($urandom_range(0, 125));
                else len = 64'($urandom_range(1, 12));
            end else if (r < 90) begin
                form = 1;
                if ($urandom_range(0, 15) == 0) len = 64'($urandom_range(0, 300));
                else len = 64'($urandom_range(0, 24));
            end else begin
                form = 2;
                len  = 64'($urandom_range(0, 16));
            end
            // receiver holds off during a long payload so the output register backs up
            if (!pressed && bytes_sent > 500) begin
                pressed       = 1'b1;
                steady        = 1'b0;
                hold_long_req = 1'b1;
                form          = 0;
                len           = 64'd80;
            end
            if (!drained && bytes_sent > 900) begin
                drained = 1'b1;
                go_quiet();
                while (tracker.due_words.size() != 0) @(posedge i_clk);
            end
            send_frame(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), form, len, int'(len), $urandom());
        end

        // frame with top length bit set never finishes, so it goes last
        steady = 1'b0;
        send_frame(4'h2, 1'b0, 1'b1, 2, 64'hFFFF_FFFF_FFFF_FFFF, 9, $urandom());
        go_quiet();
        while (tracker.due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.fails == 0 && tracker.due_words.size() == 0) begin
            $display("** websocket_frame_deframer_top: PASSED **");
        end else begin
            $display("** websocket_frame_deframer_top: FAILED **");
        end
        $finish;
    end

endmodule
